@@ rtl/bracket_balance_checker_macros.svh @@
// Assertion macros shared by the bracket balance checker RTL
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BBC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bracket balance checker: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define BBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bracket balance checker: next-cycle check failed");

`endif

@@ rtl/bbc_pkg.sv @@
// Types, character codes and decode helpers for the bracket balance checker
package bbc_pkg;

   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_NONE         = 8'h00;
   localparam logic [7:0] COUNT_MAX         = 8'hFF;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_CURLY  = 2'd1,
      KIND_SQUARE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_BALANCED    = 2'd0,
      VERDICT_OPEN_LEFT   = 2'd1,
      VERDICT_EXTRA_CLOSE = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
   } req_type;

   typedef struct packed {
      logic       extra_closer;
      logic       stack_overflow;
      logic       done_res;
      logic [1:0] verdict;
      logic [7:0] missing_closer;
      logic [7:0] error_total;
   } rsp_type;

   // Decoded bracket: whether it opens, closes, and its kind
   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } bracket_type;

   function automatic bracket_type decode_symbol(input logic [7:0] sym);
      bracket_type b;
      b.is_open  = 1'b0;
      b.is_close = 1'b0;
      b.kind     = KIND_ROUND;
      unique case (sym)
         CHAR_OPEN_ROUND: begin
            b.is_open = 1'b1;
            b.kind    = KIND_ROUND;
         end
         CHAR_OPEN_CURLY: begin
            b.is_open = 1'b1;
            b.kind    = KIND_CURLY;
         end
         CHAR_OPEN_SQUARE: begin
            b.is_open = 1'b1;
            b.kind    = KIND_SQUARE;
         end
         CHAR_CLOSE_ROUND: begin
            b.is_close = 1'b1;
            b.kind     = KIND_ROUND;
         end
         CHAR_CLOSE_CURLY: begin
            b.is_close = 1'b1;
            b.kind     = KIND_CURLY;
         end
         CHAR_CLOSE_SQUARE: begin
            b.is_close = 1'b1;
            b.kind     = KIND_SQUARE;
         end
         default: begin
            b.is_open  = 1'b0;
            b.is_close = 1'b0;
         end
      endcase
      return b;
   endfunction

   function automatic logic [7:0] closer_char(input kind_type kind);
      logic [7:0] c;
      unique case (kind)
         KIND_ROUND:  c = CHAR_CLOSE_ROUND;
         KIND_CURLY:  c = CHAR_CLOSE_CURLY;
         KIND_SQUARE: c = CHAR_CLOSE_SQUARE;
         default:     c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/bracket_balance_checker.sv @@
// Bracket balance checker top level: stack in a synchronous memory, top kept in a register.
// Latency: each accepted word's result word is in the output register in the cycle after it is accepted.
// Throughput: one word per cycle while the output is not stalled; the top-of-stack register and the registered
// read of the entry below it, with a bypass after a push, let every character see the updated stack.
// Reset: fill count, error count and valid flags clear at once; the stack memory is not
// cleared, since only entries below the fill count are ever used.
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

`include "bracket_balance_checker_macros.svh"

   localparam int MemDepth = (STACK_DEPTH > 1) ? STACK_DEPTH : 2;
   localparam int AW       = $clog2(MemDepth);
   localparam int FW       = $clog2(STACK_DEPTH + 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);
   localparam logic [FW-1:0] FILL_ONE  = FW'(1);
   localparam logic [FW-1:0] FILL_TWO  = FW'(2);

   // Entries below the top; the top itself lives in top_ff
   logic [1:0] stack_mem [MemDepth];

   logic [FW-1:0] fill_ff;
   logic [7:0]    extra_ff;
   kind_type      top_ff;
   logic          byp_ff;
   kind_type      byp_kind_ff;
   logic [1:0]    rd_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          accept;
   bracket_type   br;
   logic          full, empty, match;
   logic          do_push, do_pop, extra, ovf;
   kind_type      second;
   kind_type      top_in;
   logic [FW-1:0] fill_step;
   logic [FW-1:0] fill_in;
   logic [7:0]    count_step;
   logic [FW-1:0] wr_fill;
   logic [FW-1:0] rd_fill;
   logic [FW-1:0] rd_fill_sub;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   rsp_type       rsp_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      br      = decode_symbol(req_word.symbol);
      full    = (fill_ff == FILL_FULL);
      empty   = (fill_ff == '0);
      // forward the old top in the cycle after a push to the address being read
      second  = byp_ff ? byp_kind_ff : kind_type'(rd_data_ff);
      match   = !empty && (top_ff == br.kind);
      do_push = br.is_open && !full;
      ovf     = br.is_open && full;
      do_pop  = br.is_close && match;
      extra   = br.is_close && !match;

      fill_step = fill_ff;
      top_in    = top_ff;
      if (do_push) begin
         fill_step = fill_ff + FILL_ONE;
         top_in    = br.kind;
      end else if (do_pop) begin
         fill_step = fill_ff - FILL_ONE;
         top_in    = second;
      end

      count_step = extra_ff;
      if (extra && (extra_ff != COUNT_MAX)) begin
         count_step = extra_ff + 8'd1;
      end

      fill_in = req_word.last_symbol ? '0 : fill_step;

      rsp_in.extra_closer   = extra;
      rsp_in.stack_overflow = ovf;
      rsp_in.done_res       = req_word.last_symbol;
      rsp_in.verdict        = VERDICT_BALANCED;
      rsp_in.missing_closer = CHAR_NONE;
      rsp_in.error_total    = count_step;
      if (req_word.last_symbol) begin
         if (fill_step != '0) begin
            rsp_in.verdict        = VERDICT_OPEN_LEFT;
            rsp_in.missing_closer = closer_char(top_in);
         end else if (count_step != '0) begin
            rsp_in.verdict = VERDICT_EXTRA_CLOSE;
         end
      end

      // push spills the old top below the new one
      wr_en   = accept && do_push && !empty;
      wr_fill = fill_ff - FILL_ONE;
      wr_addr = wr_fill[AW-1:0];

      // keep the read pointed at the entry below the top as it stands after this edge
      rd_fill     = accept ? fill_in : fill_ff;
      rd_fill_sub = rd_fill - FILL_TWO;
      rd_addr     = (rd_fill >= FILL_TWO) ? rd_fill_sub[AW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         extra_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         byp_ff <= accept && do_push;
         if (accept) begin
            fill_ff  <= fill_in;
            extra_ff <= req_word.last_symbol ? 8'd0 : count_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_kind_ff <= top_ff;
      if (accept) begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `BBC_ASSERT_NOW(a_fill_range, 1'b1, fill_ff <= FILL_FULL)
   `BBC_ASSERT_NEXT(a_last_clears, accept && req_word.last_symbol, fill_ff == '0 && extra_ff == '0)
   `BBC_ASSERT_NEXT(a_push_grows, accept && do_push && !req_word.last_symbol, fill_ff == $past(fill_ff) + FILL_ONE)
   `BBC_ASSERT_NEXT(a_count_monotonic, accept && !req_word.last_symbol, extra_ff >= $past(extra_ff))
   `BBC_ASSERT_NOW(a_overflow_full, accept && ovf, fill_ff == FILL_FULL && !extra)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the bracket balance checker: directed cases and random bracket streams
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bbc_pkg::*;

   localparam int DEPTH        = 64;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 8;

   localparam int SHAPE_WELL   = 0;
   localparam int SHAPE_BROKEN = 1;
   localparam int SHAPE_NOISE  = 2;
   localparam int SHAPE_DEEP   = 3;
   localparam int SHAPE_FLOOD  = 4;

   localparam int STALL_NONE      = 0;
   localparam int STALL_RANDOM    = 1;
   localparam int STALL_ALTERNATE = 2;
   localparam int STALL_HEAVY     = 3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   bracket_balance_checker #(.STACK_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   req_type  char_queue[$];
   rsp_type  expected_status[$];
   kind_type open_kinds[DEPTH];
   int       open_fill     = 0;
   int       closer_errors = 0;
   int       mismatches    = 0;
   int       cycle_count   = 0;
   int       words_taken   = 0;
   bit       word_taken    = 1'b0;
   int       burst_left    = 0;
   int       gap_left      = 0;
   int       stall_mode    = STALL_NONE;
   int       mode_left     = 0;
   int       hold_left     = 0;
   bit       hold_done     = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic kind_type any_kind();
      return kind_type'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] open_char(kind_type k);
      case (k)
         KIND_CURLY:  return CHAR_OPEN_CURLY;
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         default:     return CHAR_OPEN_ROUND;
      endcase
   endfunction

   function automatic logic [7:0] close_char(kind_type k);
      case (k)
         KIND_CURLY:  return CHAR_CLOSE_CURLY;
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         default:     return CHAR_CLOSE_ROUND;
      endcase
   endfunction

   // Advance the bracket stack by one character and form the status word it yields
   function automatic rsp_type track_brackets(req_type w);
      rsp_type  r;
      kind_type k;
      bit       opens;
      bit       closes;
      r      = '0;
      k      = KIND_ROUND;
      opens  = 1'b0;
      closes = 1'b0;
      case (w.symbol)
         CHAR_OPEN_ROUND: begin
            opens = 1'b1;
            k     = KIND_ROUND;
         end
         CHAR_OPEN_CURLY: begin
            opens = 1'b1;
            k     = KIND_CURLY;
         end
         CHAR_OPEN_SQUARE: begin
            opens = 1'b1;
            k     = KIND_SQUARE;
         end
         CHAR_CLOSE_ROUND: begin
            closes = 1'b1;
            k      = KIND_ROUND;
         end
         CHAR_CLOSE_CURLY: begin
            closes = 1'b1;
            k      = KIND_CURLY;
         end
         CHAR_CLOSE_SQUARE: begin
            closes = 1'b1;
            k      = KIND_SQUARE;
         end
         default: ;
      endcase
      if (opens) begin
         if (open_fill < DEPTH) begin
            open_kinds[open_fill] = k;
            open_fill++;
         end else begin
            r.stack_overflow = 1'b1;
         end
      end else if (closes) begin
         if (open_fill == 0 || open_kinds[open_fill - 1] != k) begin
            r.extra_closer = 1'b1;
            if (closer_errors < 255) closer_errors++;
         end else begin
            open_fill--;
         end
      end
      r.error_total = closer_errors[7:0];
      if (w.last_symbol) begin
         r.done_res = 1'b1;
         if (open_fill != 0) begin
            r.verdict        = VERDICT_OPEN_LEFT;
            r.missing_closer = close_char(open_kinds[open_fill - 1]);
         end else if (closer_errors != 0) begin
            r.verdict = VERDICT_EXTRA_CLOSE;
         end else begin
            r.verdict = VERDICT_BALANCED;
         end
         open_fill     = 0;
         closer_errors = 0;
      end
      return r;
   endfunction

   function automatic void push_char(logic [7:0] c, bit last);
      req_type item;
      item.symbol      = c;
      item.last_symbol = last;
      char_queue.push_back(item);
   endfunction

   // Queue one expression; return how many words it holds
   function automatic int queue_expression(int shape);
      logic [7:0] chars[$];
      kind_type   open_seen[$];
      kind_type   k;
      int         steps;
      bit         last;
      steps   = $urandom_range(1, 24);
      case (shape)
         SHAPE_DEEP: begin
            repeat ($urandom_range(DEPTH - 2, DEPTH + 4)) chars.push_back(open_char(any_kind()));
            repeat ($urandom_range(0, 4)) chars.push_back(close_char(any_kind()));
         end
         SHAPE_FLOOD: begin
            repeat ($urandom_range(256, 270)) chars.push_back(close_char(any_kind()));
         end
         SHAPE_NOISE: begin
            repeat (steps) chars.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            repeat (steps) begin
               if ($urandom_range(0, 4) == 0) begin
                  chars.push_back(8'($urandom_range(0, 255)));
               end else if (open_seen.size() == 0 || $urandom_range(0, 1) == 1) begin
                  k = any_kind();
                  open_seen.push_back(k);
                  chars.push_back(open_char(k));
               end else begin
                  chars.push_back(close_char(open_seen.pop_back()));
               end
            end
            if (shape == SHAPE_WELL) begin
               while (open_seen.size() > 0) chars.push_back(close_char(open_seen.pop_back()));
            end else begin
               // leave some openers open, then plant a stray bracket somewhere
               repeat ($urandom_range(0, open_seen.size()))
                  chars.push_back(close_char(open_seen.pop_back()));
               k = any_kind();
               chars.insert($urandom_range(0, chars.size()),
                            ($urandom_range(0, 1) == 1) ? close_char(k) : open_char(k));
            end
         end
      endcase
      foreach (chars[i]) begin
         last = (i == chars.size() - 1);
         push_char(chars[i], last);
      end
      return chars.size();
   endfunction

   task automatic wait_drained();
      while (char_queue.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Sender: bursts of words with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         word_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_queue.size() > 0) begin
            req_word  <= char_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes at random intervals, plus one long hold
   always @(negedge clock) begin
      if (!hold_done && words_taken >= 150 && char_queue.size() > 50) begin
         hold_done = 1'b1;
         hold_left = 300;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
         mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM:    rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_ALTERNATE: rsp_stall <= (cycle_count % 2 == 1);
            STALL_HEAVY:     rsp_stall <= ($urandom_range(0, 3) != 0);
            default:         rsp_stall <= 1'b0;
         endcase
      end
   end

   // Take accepted words into the predictor and check result words
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         if (!reset && req_valid && !req_stall) begin
            expected_status.push_back(track_brackets(req_word));
            words_taken++;
            word_taken = 1'b1;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = expected_status.pop_front();
               check_field("extra_closer", rsp_word.extra_closer, want.extra_closer);
               check_field("stack_overflow", rsp_word.stack_overflow, want.stack_overflow);
               check_field("done_res", rsp_word.done_res, want.done_res);
               check_field("verdict", rsp_word.verdict, want.verdict);
               check_field("missing_closer", rsp_word.missing_closer, want.missing_closer);
               check_field("error_total", rsp_word.error_total, want.error_total);
            end
         end
      end
   end

   initial begin
      int random_count;
      int chunk_count;
      int pick;
      // single openers and closers, matched pairs, mismatch with opener left, extra after balance
      push_char(CHAR_OPEN_ROUND, 1'b1);
      push_char(CHAR_OPEN_CURLY, 1'b1);
      push_char(CHAR_OPEN_SQUARE, 1'b1);
      push_char(CHAR_CLOSE_ROUND, 1'b1);
      push_char(CHAR_OPEN_ROUND, 1'b0);
      push_char(CHAR_CLOSE_ROUND, 1'b1);
      push_char(CHAR_OPEN_CURLY, 1'b0);
      push_char(CHAR_CLOSE_SQUARE, 1'b1);
      push_char(CHAR_OPEN_SQUARE, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(CHAR_CLOSE_SQUARE, 1'b1);
      push_char(CHAR_OPEN_CURLY, 1'b0);
      push_char(CHAR_CLOSE_CURLY, 1'b0);
      push_char(CHAR_CLOSE_CURLY, 1'b1);
      push_char(CHAR_OPEN_SQUARE, 1'b0);
      push_char(CHAR_OPEN_ROUND, 1'b0);
      push_char(CHAR_CLOSE_SQUARE, 1'b1);
      push_char(8'h00, 1'b1);
      push_char(8'hFF, 1'b1);
      push_char(8'h41, 1'b1);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // count saturation and a full stack first, then mostly nested expressions
      chunk_count  = queue_expression(SHAPE_FLOOD);
      chunk_count += queue_expression(SHAPE_DEEP);
      random_count = 0;
      while (random_count + chunk_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 11)
            chunk_count += queue_expression(SHAPE_WELL);
         else if (pick < 16)
            chunk_count += queue_expression(SHAPE_BROKEN);
         else if (pick < 18)
            chunk_count += queue_expression(SHAPE_NOISE);
         else
            chunk_count += queue_expression(SHAPE_DEEP);
         if (chunk_count >= 250) begin
            random_count += chunk_count;
            chunk_count = 0;
            wait_drained();
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
